@@ sv/fdseq_pkg.sv @@
// shared types, codes and defaults of the frame duration sequencer
package fdseq_pkg;

  // default sizes
  localparam int MAX_FRAMES_DEF    = 64;
  localparam int DURATION_BITS_DEF = 16;

  // fixed field widths
  localparam int ACTION_W     = 2;
  localparam int ELAPSED_W    = 16;
  localparam int ENTRY_IDX_W  = 6;
  localparam int ENTRY_DUR_W  = 16;
  localparam int FRAME_IDX_W  = 6;
  localparam int ADVANCED_W   = 16;
  localparam int FRAME_CNT_W  = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 24;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 1'b0,
    CFG_REPEAT_MODE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [FRAME_CNT_W-1:0] frame_count;
    logic                   repeat_mode;
  } cfg_t;

  typedef struct packed {
    logic                   running;
    logic                   ended;
    logic [ADVANCED_W-1:0]  frames_advanced;
    logic [FRAME_IDX_W-1:0] frame_pos;
  } res_t;

endpackage

@@ sv/fdseq_dur_mem.sv @@
// duration table: one write port, one read port, registered read data
module fdseq_dur_mem
  import fdseq_pkg::*;
#(
  parameter int DEPTH = MAX_FRAMES_DEF,
  parameter int DW    = DURATION_BITS_DEF,
  parameter int AW    = $clog2(MAX_FRAMES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/fdseq_ctrl.sv @@
// sequencer control: item decode, per-frame walk over the duration table, result
module fdseq_ctrl
  import fdseq_pkg::*;
#(
  parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF,
  parameter int FI_W          = $clog2(MAX_FRAMES_DEF)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACTION_W-1:0]      in_action,
  input  logic [ELAPSED_W-1:0]     in_elapsed,
  input  logic [ENTRY_IDX_W-1:0]   in_index,
  input  logic [ENTRY_DUR_W-1:0]   in_duration,
  output logic                     mem_we,
  output logic [FI_W-1:0]          mem_waddr,
  output logic [DURATION_BITS-1:0] mem_wdata,
  output logic [FI_W-1:0]          mem_raddr,
  input  logic [DURATION_BITS-1:0] mem_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res
);

  localparam int DUR_W  = DURATION_BITS;
  localparam int TIME_W = ((DUR_W > ELAPSED_W) ? DUR_W : ELAPSED_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DONE
  } state_t;

  state_t               state;
  logic [FI_W-1:0]      cur_frame;
  logic [TIME_W-1:0]    time_in;
  logic                 active;
  logic                 ended;
  logic [ADVANCED_W-1:0] advanced;

  logic                 accept;
  action_t              act;
  logic [FI_W-1:0]      last;
  logic [DUR_W-1:0]     dur_eff;
  logic [TIME_W-1:0]    dur_ext;
  logic                 covered;
  logic                 at_last;
  logic [FI_W-1:0]      frame_next;
  logic [DUR_W-1:0]     wr_dur;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign act       = action_t'(in_action);
  assign res_valid = (state == S_DONE);

  // last frame in use, out-of-range counts clamped
  always_comb begin
    if (cfg.frame_count == '0) begin
      last = '0;
    end else if (32'(cfg.frame_count) > MAX_FRAMES) begin
      last = FI_W'(MAX_FRAMES - 1);
    end else begin
      last = FI_W'(32'(cfg.frame_count) - 32'd1);
    end
  end

  // duration of the frame under test, zero read as one
  assign dur_eff = (mem_rdata == '0) ? DUR_W'(1) : mem_rdata;
  assign dur_ext = TIME_W'(dur_eff);
  assign covered = (dur_ext <= time_in);
  assign at_last = (cur_frame >= last);

  always_comb begin
    if (at_last) begin
      frame_next = cfg.repeat_mode ? '0 : cur_frame;
    end else begin
      frame_next = cur_frame + FI_W'(1);
    end
  end

  // read the current frame on entry, the following frame while walking
  assign mem_raddr = (state == S_CHECK) ? frame_next : cur_frame;

  assign wr_dur    = DUR_W'(in_duration);
  assign mem_we    = accept && (act == ACT_WRITE) && (32'(in_index) < MAX_FRAMES);
  assign mem_waddr = FI_W'(in_index);
  assign mem_wdata = (wr_dur == '0) ? DUR_W'(1) : wr_dur;

  assign res.frame_pos       = FRAME_IDX_W'(cur_frame);
  assign res.frames_advanced = advanced;
  assign res.ended           = ended;
  assign res.running         = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_frame <= '0;
      time_in   <= '0;
      active    <= 1'b1;
      ended     <= 1'b0;
      advanced  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ended    <= 1'b0;
            advanced <= '0;
            state    <= S_DONE;
            unique case (act)
              ACT_TICK: begin
                if (active) begin
                  time_in <= time_in + TIME_W'(in_elapsed);
                  state   <= S_CHECK;
                end
              end
              ACT_RESTART: begin
                cur_frame <= '0;
                time_in   <= '0;
                active    <= 1'b1;
              end
              ACT_WRITE, ACT_NOP: begin
              end
            endcase
          end
        end
        S_CHECK: begin
          if (!covered) begin
            state <= S_DONE;
          end else begin
            time_in <= time_in - dur_ext;
            if (at_last && !cfg.repeat_mode) begin
              // last frame kept, not counted as an advance
              active <= 1'b0;
              ended  <= 1'b1;
              state  <= S_DONE;
            end else begin
              cur_frame <= frame_next;
              if (advanced != '1) begin
                advanced <= advanced + ADVANCED_W'(1);
              end
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/frame_duration_sequencer_top.sv @@
// top level of the frame duration sequencer: ports, config registers, output register
//
// The sequencer walks a table of per-frame durations (milliseconds) and
// produces one result for every request. A tick request adds elapsed_ms to
// the time spent in the current frame; while that time covers the current
// frame's duration the duration is taken off and the frame advances, wrapping
// to frame 0 in repeat mode or stopping on the last frame otherwise (ended
// set, running cleared, leftover time kept). Ticks are ignored while stopped.
// A write request loads one duration (zero is stored as one, indexes past the
// table are dropped) and a restart request returns to frame 0 and runs again.
// Durations sit in a single-port-read synchronous memory that is read one
// entry per cycle while a tick walks the frames; the input is held until the
// request's result is taken by the output register, and a write, restart, no-op
// or a tick while stopped goes straight to its result. The memory has no reset: reading a
// frame whose duration was never written gives an undefined result. The result
// register lets the next request be taken while a result still waits on the
// output. The user must write frame_count and repeat_mode through the config
// port only while the block has no request in flight; the block does not enforce it.
module frame_duration_sequencer_top
  import fdseq_pkg::*;
#(
  parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // action[1:0], elapsed_ms[17:2], entry_index[23:18], entry_duration[39:24]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // frame_pos[5:0], frames_advanced[21:6], ended[22], running[23]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // config writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FI_W = $clog2(MAX_FRAMES);

  cfg_t                     cfg;
  logic                     mem_we;
  logic [FI_W-1:0]          mem_waddr;
  logic [DURATION_BITS-1:0] mem_wdata;
  logic [FI_W-1:0]          mem_raddr;
  logic [DURATION_BITS-1:0] mem_rdata;
  logic                     res_valid;
  logic                     res_ready;
  res_t                     res;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_count <= FRAME_CNT_W'(1);
      cfg.repeat_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_COUNT: cfg.frame_count <= FRAME_CNT_W'(cfg_data);
        CFG_REPEAT_MODE: cfg.repeat_mode <= cfg_data[0];
      endcase
    end
  end

  fdseq_ctrl #(
    .MAX_FRAMES   (MAX_FRAMES),
    .DURATION_BITS(DURATION_BITS),
    .FI_W         (FI_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tdata[1:0]),
    .in_elapsed (s_tdata[17:2]),
    .in_index   (s_tdata[23:18]),
    .in_duration(s_tdata[39:24]),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  fdseq_dur_mem #(
    .DEPTH(MAX_FRAMES),
    .DW   (DURATION_BITS),
    .AW   (FI_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register, refilled in the cycle it empties
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res;
    end
  end

endmodule

@@ sv/fdseq_checker.sv @@
// port checker for the frame duration sequencer, bound to the top level
module fdseq_checker
  import fdseq_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // an ended run is never reported as running
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[22] && m_tdata[23]))
    else $error("ended and running both set");

  // reset empties the output register
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // the engine is busy right after taking a request
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while previous one in flight");

endmodule

bind frame_duration_sequencer_top fdseq_checker u_fdseq_checker (.*);

@@ verif/frame_duration_sequencer_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the frame duration sequencer top level
module frame_duration_sequencer_top_tb;
  import fdseq_pkg::*;

  // run shape
  localparam int          NUM_REQS    = 1350;     // random requests that do real work
  localparam int          ADV_CAP     = 600;      // random ticks advance at most this far
  localparam int          MAX_REPORTS = 10;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          TAB_DEPTH   = MAX_FRAMES_DEF;

  // one row of the directed table: a request, or a pair of register writes
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t              kind;
    action_t                act;
    logic [ELAPSED_W-1:0]   elapsed;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [ENTRY_DUR_W-1:0] dur;
    logic [FRAME_CNT_W-1:0] cnt;
    logic                   rep;
    logic                   typed;   // want holds a hand-written result
    res_t                   want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // action[1:0], elapsed_ms[17:2], entry_index[23:18], entry_duration[39:24]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // frame_pos[5:0], frames_advanced[21:6], ended[22], running[23]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_duration_sequencer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // sequencer state as the testbench sees it
  // ---------------------------------------------------------------------------
  logic [ENTRY_DUR_W-1:0] dur_tab [0:TAB_DEPTH-1];
  logic [FRAME_IDX_W-1:0] cur_frame  = '0;
  int unsigned            frame_time = 0;     // ms spent in the current frame
  bit                     model_run  = 1'b1;
  logic [FRAME_CNT_W-1:0] cnt_reg    = 7'd1;
  logic                   rep_reg    = 1'b0;

  res_t pending_res[$];   // results still owed by the block, oldest first

  // run bookkeeping
  bit          src_calm = 1'b0;   // sender never pauses in this phase
  bit          snk_calm = 1'b0;   // receiver never stalls in this phase
  int          mismatches = 0;
  int          n_reqs = 0;
  int          n_items = 0;
  int          n_ticks = 0;
  int          n_ends = 0;
  int          n_sat = 0;
  int          n_cfg = 0;
  int          n_results = 0;
  int unsigned cycles = 0;

  // applies one request to the state and returns the result it must produce
  function automatic res_t step_model(input action_t act, input logic [15:0] el,
                                      input logic [5:0] ei, input logic [15:0] ed);
    res_t        r;
    int unsigned last;
    int unsigned idx;
    int unsigned t;
    int unsigned d;
    int unsigned adv;
    bit          busy;
    bit          stop_hit;
    adv = 0;
    stop_hit = 1'b0;
    case (act)
      ACT_TICK: begin
        // ticks while stopped change nothing
        if (model_run) begin
          // frame count 0 acts as 1, anything past the table as the whole table
          if (cnt_reg == 0)
            last = 0;
          else if (cnt_reg > TAB_DEPTH)
            last = TAB_DEPTH - 1;
          else
            last = cnt_reg - 1;
          idx = cur_frame;
          t = frame_time + el;
          busy = 1'b1;
          while (busy) begin
            d = (dur_tab[idx] == 0) ? 1 : dur_tab[idx];
            if (d > t) begin
              busy = 1'b0;
            end else begin
              t = t - d;
              // a frame at or past the last one in use counts as the last
              if (idx >= last) begin
                if (rep_reg) begin
                  idx = 0;
                end else begin
                  // end of a one-shot run: frame kept, not an advance
                  model_run = 1'b0;
                  stop_hit = 1'b1;
                  busy = 1'b0;
                end
              end else begin
                idx++;
              end
              if (busy && adv < 65535)
                adv++;
            end
          end
          cur_frame = idx[FRAME_IDX_W-1:0];
          frame_time = t;
        end
      end
      ACT_WRITE: begin
        // a zero duration is kept as one
        dur_tab[ei] = (ed == 0) ? 16'd1 : ed;
      end
      ACT_RESTART: begin
        cur_frame = '0;
        frame_time = 0;
        model_run = 1'b1;
      end
      default: ;
    endcase
    r.frame_pos = cur_frame;
    r.frames_advanced = adv[ADVANCED_W-1:0];
    r.ended = stop_hit;
    r.running = model_run;
    return r;
  endfunction

  function automatic res_t mk_res(input int f, input int adv, input bit e, input bit run);
    res_t r;
    r.frame_pos = f[FRAME_IDX_W-1:0];
    r.frames_advanced = adv[ADVANCED_W-1:0];
    r.ended = e;
    r.running = run;
    return r;
  endfunction

  function automatic row_t req_row(input action_t a, input int el, input int ei, input int ed,
                                   input bit typed, input res_t want);
    row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.act = a;
    r.elapsed = el[ELAPSED_W-1:0];
    r.idx = ei[ENTRY_IDX_W-1:0];
    r.dur = ed[ENTRY_DUR_W-1:0];
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t cfg_row(input int cnt, input bit rep);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.act = ACT_NOP;
    r.cnt = cnt[FRAME_CNT_W-1:0];
    r.rep = rep;
    return r;
  endfunction

  // per-request pause of either side, none at all in calm phases
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // half of the durations are short so that ticks walk many frames
  function automatic logic [15:0] rand_dur();
    logic [15:0] d;
    if ($urandom_range(0, 1) == 1)
      d = 16'($urandom_range(0, 40));
    else
      d = 16'($urandom_range(0, 65535));
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: valid stays high across back-to-back requests
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  // predicts, sends and books one request; capped ticks get their elapsed
  // time halved until the walk stays short
  task automatic issue_req(input action_t a, input logic [15:0] el, input logic [5:0] ei,
                           input logic [15:0] ed, input bit capped, input bit typed,
                           input res_t typed_res);
    res_t                   want;
    logic [FRAME_IDX_W-1:0] keep_frame;
    int unsigned            keep_time;
    bit                     keep_run;
    keep_frame = cur_frame;
    keep_time = frame_time;
    keep_run = model_run;
    want = step_model(a, el, ei, ed);
    while (capped && want.frames_advanced > ADV_CAP) begin
      cur_frame = keep_frame;
      frame_time = keep_time;
      model_run = keep_run;
      el = el >> 1;
      want = step_model(a, el, ei, ed);
    end
    if (typed)
      want = typed_res;
    send_req({ed, ei, el, a});
    pending_res.push_back(want);
    n_reqs++;
    // a tick while stopped is ignored by the block and not counted as work
    if (!(a == ACT_TICK && !keep_run))
      n_items++;
    if (a == ACT_TICK)
      n_ticks++;
    if (want.ended)
      n_ends++;
    if (want.frames_advanced == 16'hFFFF)
      n_sat++;
  endtask

  // lower valid and wait until every result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // both registers back to back, the block being idle
  task automatic write_regs(input logic [FRAME_CNT_W-1:0] cnt, input logic rep);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FRAME_COUNT;
    cfg_data <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_REPEAT_MODE;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, rep};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cnt_reg = cnt;
    rep_reg = rep;
    n_cfg += 2;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, then compare with the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_gap(snk_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic report_bad(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%s at cycle %0d: expected frame %0d adv %0d ended %0b running %0b, got %s",
               what, cycles, want.frame_pos, want.frames_advanced, want.ended,
               want.running,
               $sformatf("frame %0d adv %0d ended %0b running %0b", got.frame_pos,
                         got.frames_advanced, got.ended, got.running));
  endtask

  always @(posedge clk) begin : check_res
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata);
      n_results++;
      if (pending_res.size() == 0) begin
        report_bad("result with no request outstanding", '0, got);
      end else begin
        want = pending_res.pop_front();
        if (got.frame_pos !== want.frame_pos ||
            got.frames_advanced !== want.frames_advanced ||
            got.ended !== want.ended || got.running !== want.running)
          report_bad("wrong result", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_res.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t                   rows[$];
    action_t                act;
    logic [ELAPSED_W-1:0]   el;
    logic [ENTRY_IDX_W-1:0] ei;
    logic [ENTRY_DUR_W-1:0] ed;
    logic [FRAME_CNT_W-1:0] cnt;
    int                     pick;
    int                     len;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset settings: one frame, no repeat
    rows.push_back(req_row(ACT_NOP, 0, 0, 0, 1'b1,
                           mk_res(0, 0, 1'b0, 1'b1)));                        // reset state
    rows.push_back(req_row(ACT_WRITE, 0, 0, 0, 1'b1,
                           mk_res(0, 0, 1'b0, 1'b1)));                        // zero kept as one
    rows.push_back(req_row(ACT_TICK, 0, 0, 0, 1'b1,
                           mk_res(0, 0, 1'b0, 1'b1)));                        // no time passed
    rows.push_back(req_row(ACT_TICK, 1, 0, 0, 1'b1,
                           mk_res(0, 0, 1'b1, 1'b0)));                        // one-shot ends
    rows.push_back(req_row(ACT_TICK, 65535, 0, 0, 1'b1,
                           mk_res(0, 0, 1'b0, 1'b0)));                        // ignored, stopped
    rows.push_back(req_row(ACT_RESTART, 0, 0, 0, 1'b1, mk_res(0, 0, 1'b0, 1'b1)));
    rows.push_back(req_row(ACT_WRITE, 0, 63, 65535, 1'b1, mk_res(0, 0, 1'b0, 1'b1)));
    rows.push_back(req_row(ACT_WRITE, 0, 1, 3, 1'b0, '0));
    // two frames looping: a tick that wraps within itself
    rows.push_back(cfg_row(2, 1'b1));
    rows.push_back(req_row(ACT_TICK, 5, 0, 0, 1'b0, '0));
    rows.push_back(req_row(ACT_NOP, 65535, 63, 65535, 1'b0, '0));             // all ones, no-op
    // park on frame 1 with almost its whole duration spent
    rows.push_back(req_row(ACT_WRITE, 0, 1, 65535, 1'b0, '0));
    rows.push_back(req_row(ACT_RESTART, 0, 0, 0, 1'b1, mk_res(0, 0, 1'b0, 1'b1)));
    rows.push_back(req_row(ACT_TICK, 65535, 0, 0, 1'b0, '0));
    // shrink to one frame so the current frame lies past the count,
    // then a walk long enough to saturate the advance count
    rows.push_back(cfg_row(1, 1'b1));
    rows.push_back(req_row(ACT_WRITE, 0, 1, 1, 1'b0, '0));
    rows.push_back(req_row(ACT_TICK, 65535, 0, 0, 1'b1, mk_res(0, 65535, 1'b0, 1'b1)));
    // one-shot end with leftover time, then a tick while stopped
    rows.push_back(cfg_row(2, 1'b0));
    rows.push_back(req_row(ACT_TICK, 100, 0, 0, 1'b0, '0));
    rows.push_back(req_row(ACT_TICK, 7, 0, 0, 1'b1, mk_res(1, 0, 1'b0, 1'b0)));
    rows.push_back(req_row(ACT_RESTART, 0, 0, 0, 1'b0, '0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_regs(rows[i].cnt, rows[i].rep);
      end else begin
        issue_req(rows[i].act, rows[i].elapsed, rows[i].idx, rows[i].dur, 1'b0,
                  rows[i].typed, rows[i].want);
      end
    end

    // load every table entry so that any frame count can be walked
    n_items = 0;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      el = 16'($urandom_range(0, 65535));
      ed = rand_dur();
      issue_req(ACT_WRITE, el, i[ENTRY_IDX_W-1:0], ed, 1'b1, 1'b0, '0);
    end

    // random phases, each with its own settings and idling style
    while (n_items < NUM_REQS) begin
      settle();
      case ($urandom_range(0, 7))
        0:       cnt = 7'd0;
        1:       cnt = 7'd1;
        2:       cnt = 7'd64;
        3:       cnt = 7'd127;
        4:       cnt = 7'($urandom_range(65, 127));
        5, 6:    cnt = 7'($urandom_range(1, 8));
        default: cnt = 7'($urandom_range(1, 64));
      endcase
      write_regs(cnt, 1'($urandom_range(0, 1)));
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 60);
      for (int k = 0; k < len; k++) begin
        // mostly ticks; a stopped run is usually restarted
        pick = $urandom_range(0, 99);
        if (!model_run && pick < 50)
          act = ACT_RESTART;
        else if (pick < 65)
          act = ACT_TICK;
        else if (pick < 80)
          act = ACT_WRITE;
        else if (pick < 90)
          act = ACT_RESTART;
        else
          act = ACT_NOP;
        el = 16'($urandom_range(0, 65535));
        ei = 6'($urandom_range(0, 63));
        ed = rand_dur();
        if (act == ACT_TICK) begin
          case ($urandom_range(0, 3))
            0, 1:    el = 16'($urandom_range(0, 50));
            2:       el = 16'($urandom_range(0, 2000));
            default: ;
          endcase
        end
        issue_req(act, el, ei, ed, 1'b1, 1'b0, '0);
      end
    end

    // drain, then give stray results a chance to show up
    settle();
    repeat (20) @(posedge clk);

    $display("sent %0d requests: %0d ticks, %0d one-shot ends, %0d saturated walks",
             n_reqs, n_ticks, n_ends, n_sat);
    $display("%0d register writes, %0d results checked over %0d cycles",
             n_cfg, n_results, cycles);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
